### rtl/gcsb_pkg.sv
// shared types and constants for the glyph coverage scale and blend core
// no dependencies
package gcsb_pkg;

    localparam int GLYPH_WIDTH_DEF  = 12;
    localparam int GLYPH_HEIGHT_DEF = 24;

    // scaled sample position numerator, divisor and quotient widths
    localparam int NUM_W = 23;
    localparam int DEN_W = 7;
    localparam int QUO_W = 16;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PAINT = 1'b1;

    // what travels beside the datapath through every stage
    typedef struct packed {
        logic        valid;
        logic        paint;
        logic        wr_ok;
        logic [8:0]  idx;
        logic [7:0]  val;
        logic [23:0] dest;
    } t_tag;

endpackage

### rtl/gcsb_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module gcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 288
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/gcsb_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on gcsb_pkg
module gcsb_div (
    input  logic                        i_clk,
    input  logic                        i_adv,
    input  logic [gcsb_pkg::NUM_W-1:0] i_num,
    input  logic [gcsb_pkg::DEN_W-1:0] i_den,
    output logic [gcsb_pkg::QUO_W-1:0] o_quo
);

    localparam int QW = gcsb_pkg::QUO_W;
    localparam int DW = gcsb_pkg::DEN_W;

    logic [DW-1:0] r_rem [1:QW];
    logic [QW-1:0] r_low [1:QW];
    logic [QW-1:0] r_quo [1:QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            logic [DW-1:0] w_rem;
            logic [QW-1:0] w_low;
            logic [QW-1:0] w_quo;
            logic [DW:0]   w_trial;
            logic          w_ge;
            logic [DW:0]   w_diff;

            if (s == 0) begin : g_first
                // the top bits are already below the divisor
                assign w_rem = i_num[gcsb_pkg::NUM_W-1:QW];
                assign w_low = i_num[QW-1:0];
                assign w_quo = '0;
            end else begin : g_next
                assign w_rem = r_rem[s];
                assign w_low = r_low[s];
                assign w_quo = r_quo[s];
            end

            assign w_trial = {w_rem, w_low[QW-1]};
            assign w_ge    = w_trial >= {1'b0, i_den};
            assign w_diff  = w_trial - {1'b0, i_den};

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[s+1] <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_low[s+1] <= {w_low[QW-2:0], 1'b0};
                    r_quo[s+1] <= {w_quo[QW-2:0], w_ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW];

endmodule

### rtl/gcsb_interp.sv
// coverage store, sample addressing and bilinear weighting, three stages
// depends on gcsb_pkg and gcsb_ram
module gcsb_interp #(
    parameter int GLYPH_WIDTH  = gcsb_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = gcsb_pkg::GLYPH_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_smooth,
    input  logic [gcsb_pkg::QUO_W-1:0] i_qx,
    input  logic [gcsb_pkg::QUO_W-1:0] i_qy,
    input  gcsb_pkg::t_tag              i_tag,
    output logic [7:0]                  o_cov,
    output gcsb_pkg::t_tag              o_tag
);

    localparam int DEPTH = GLYPH_WIDTH * GLYPH_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GLYPH_WIDTH);
    localparam int YW    = $clog2(GLYPH_HEIGHT);
    localparam int QW    = gcsb_pkg::QUO_W;

    // sample position and neighbor addresses
    logic [QW-1:0] w_sx, w_sy;
    logic [XW-1:0] w_x0, w_x1;
    logic [YW-1:0] w_y0, w_y1;
    logic [7:0]    w_fx, w_fy;
    logic [AW-1:0] w_addr [0:3];
    logic [7:0]    w_rd   [0:3];
    logic          w_we;
    logic [AW-1:0] w_waddr;

    always_comb begin
        w_sx = (i_qx > QW'(128)) ? i_qx - QW'(128) : '0;
        w_sy = (i_qy > QW'(128)) ? i_qy - QW'(128) : '0;
        if (i_smooth) begin
            w_x0 = (w_sx[QW-1:8] > (QW-8)'(GLYPH_WIDTH - 1)) ?
                   XW'(GLYPH_WIDTH - 1) : XW'(w_sx[QW-1:8]);
            w_y0 = (w_sy[QW-1:8] > (QW-8)'(GLYPH_HEIGHT - 1)) ?
                   YW'(GLYPH_HEIGHT - 1) : YW'(w_sy[QW-1:8]);
            w_x1 = (w_x0 == XW'(GLYPH_WIDTH - 1)) ? w_x0 : w_x0 + XW'(1);
            w_y1 = (w_y0 == YW'(GLYPH_HEIGHT - 1)) ? w_y0 : w_y0 + YW'(1);
            w_fx = w_sx[7:0];
            w_fy = w_sy[7:0];
        end else begin
            // nearest sample: all four taps on one entry, zero weights
            w_x0 = (i_qx > QW'(GLYPH_WIDTH - 1)) ? XW'(GLYPH_WIDTH - 1) : XW'(i_qx);
            w_y0 = (i_qy > QW'(GLYPH_HEIGHT - 1)) ? YW'(GLYPH_HEIGHT - 1) : YW'(i_qy);
            w_x1 = w_x0;
            w_y1 = w_y0;
            w_fx = '0;
            w_fy = '0;
        end
        w_addr[0] = AW'(32'(w_y0) * GLYPH_WIDTH + 32'(w_x0));
        w_addr[1] = AW'(32'(w_y0) * GLYPH_WIDTH + 32'(w_x1));
        w_addr[2] = AW'(32'(w_y1) * GLYPH_WIDTH + 32'(w_x0));
        w_addr[3] = AW'(32'(w_y1) * GLYPH_WIDTH + 32'(w_x1));
        // loads write at the same stage where paints read, so order holds
        w_we    = i_adv & i_tag.valid & ~i_tag.paint & i_tag.wr_ok;
        w_waddr = AW'(i_tag.idx);
    end

    genvar k;
    generate
        for (k = 0; k < 4; k++) begin : g_copy
            gcsb_ram #(
                .WIDTH (8),
                .DEPTH (DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_we),
                .i_waddr (w_waddr),
                .i_wdata (i_tag.val),
                .i_re    (i_adv),
                .i_raddr (w_addr[k]),
                .o_rdata (w_rd[k])
            );
        end
    endgenerate

    // stage f: read data comes out of the ram registers
    gcsb_pkg::t_tag r_tag_f, r_tag_g, r_tag_h;
    logic [7:0]     r_fx_f, r_fy_f, r_fy_g;
    logic [15:0]    r_top_g, r_bot_g;
    logic [7:0]     r_cov_h;
    logic [16:0]    w_top, w_bot;
    logic [24:0]    w_mix;

    always_comb begin
        w_top = 17'(w_rd[0]) * (17'd256 - 17'(r_fx_f)) + 17'(w_rd[1]) * 17'(r_fx_f);
        w_bot = 17'(w_rd[2]) * (17'd256 - 17'(r_fx_f)) + 17'(w_rd[3]) * 17'(r_fx_f);
        w_mix = 25'(r_top_g) * (25'd256 - 25'(r_fy_g)) + 25'(r_bot_g) * 25'(r_fy_g)
                + 25'd32768;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_f.valid <= 1'b0;
            r_tag_g.valid <= 1'b0;
            r_tag_h.valid <= 1'b0;
        end else if (i_adv) begin
            r_tag_f <= i_tag;
            r_tag_g <= r_tag_f;
            r_tag_h <= r_tag_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_fx_f  <= w_fx;
            r_fy_f  <= w_fy;
            r_top_g <= w_top[15:0];
            r_bot_g <= w_bot[15:0];
            r_fy_g  <= r_fy_f;
            r_cov_h <= w_mix[23:16];
        end
    end

    assign o_cov = r_cov_h;
    assign o_tag = r_tag_h;

endmodule

### rtl/gcsb_blend.sv
// per channel alpha blend with rounding divide by 255, and the output register
// depends on gcsb_pkg
module gcsb_blend (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic [23:0]    i_fg,
    input  logic [23:0]    i_bg,
    input  logic           i_transp,
    input  logic [7:0]     i_cov,
    input  gcsb_pkg::t_tag i_tag,
    output logic           o_valid,
    output logic [23:0]    o_pixel,
    output logic [7:0]     o_cov,
    output logic           o_we
);

    logic [23:0]    w_bg;
    logic [15:0]    w_sum [0:2];
    gcsb_pkg::t_tag r_tag_i;
    logic [15:0]    r_sum_i [0:2];
    logic [7:0]     r_cov_i;
    logic [16:0]    w_q [0:2];
    logic           w_we;
    logic           r_valid;
    logic [23:0]    r_pixel;
    logic [7:0]     r_cov;
    logic           r_we;

    always_comb begin
        w_bg = i_transp ? i_tag.dest : i_bg;
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = 16'(i_fg[8*c +: 8]) * 16'(i_cov)
                     + 16'(w_bg[8*c +: 8]) * (16'd255 - 16'(i_cov)) + 16'd127;
        end
        // exact divide by 255 for sums below 65535
        for (int c = 0; c < 3; c++) begin
            w_q[c] = 17'(r_sum_i[c]) + 17'(r_sum_i[c][15:8]) + 17'd1;
        end
        w_we = ~(i_transp & (r_cov_i == 8'd0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_i.valid <= 1'b0;
            r_valid       <= 1'b0;
        end else if (i_adv) begin
            r_tag_i <= i_tag;
            r_valid <= r_tag_i.valid & r_tag_i.paint;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum_i <= w_sum;
            r_cov_i <= i_cov;
            r_cov   <= r_cov_i;
            r_we    <= w_we;
            r_pixel <= w_we ? {w_q[2][15:8], w_q[1][15:8], w_q[0][15:8]} : r_tag_i.dest;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_cov   = r_cov;
    assign o_we    = r_we;

endmodule

### rtl/glyph_coverage_scale_blend_core.sv
// top level of the glyph coverage scale and blend core
// depends on gcsb_pkg, gcsb_div, gcsb_interp, gcsb_blend
//
// Use: load items (tuser 0) write one byte of the glyph coverage store; paint
// items (tuser 1) name a pixel of the scaled cell and carry the existing
// destination pixel. Each paint item yields one transfer on the master side
// with the blended pixel, the sampled coverage and a write flag; load items
// yield none. Settings come in over the plain write port; the user must write
// them only while the core is idle, which the core does not enforce. Pipeline:
// one input register, 16 divider stages that scale the pixel position (one
// quotient bit each), three stages for store read and bilinear weighting, two
// for the blend. Throughput: one item per cycle unless stalled; all stages move as one.
// Stall: while the output holds a result the receiver does not take, every
// stage freezes and s_axis tready drops; nothing is lost or repeated.
// Reset: settings return to white on black, opaque, nearest sample, 12x24
// cell; all valid bits clear. The store is not cleared and needs no sweep;
// entries must be loaded before they are sampled.
module glyph_coverage_scale_blend_core #(
    parameter int GLYPH_WIDTH  = gcsb_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = gcsb_pkg::GLYPH_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // coverage_index[8:0], coverage_value[16:9], pixel_row[23:17],
    // pixel_col[29:24], dest_pixel[53:30], zero pad[55:54]
    input  logic [gcsb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd[0]
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_pixel[23:0], coverage[31:24]
    output logic [gcsb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // write_enable[0]
    output logic                              o_m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [gcsb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gcsb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int QW = gcsb_pkg::QUO_W;
    localparam int NW = gcsb_pkg::NUM_W;
    localparam int DW = gcsb_pkg::DEN_W;

    logic        r_transp, r_smooth;
    logic [23:0] r_fg, r_bg;
    logic [5:0]  r_cell_w;
    logic [6:0]  r_cell_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg     <= 24'hFFFFFF;
            r_bg     <= '0;
            r_transp <= 1'b0;
            r_smooth <= 1'b0;
            r_cell_w <= 6'd12;
            r_cell_h <= 7'd24;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gcsb_pkg::CFG_FG_COLOR:    r_fg     <= i_cfg_data;
                gcsb_pkg::CFG_BG_COLOR:    r_bg     <= i_cfg_data;
                gcsb_pkg::CFG_TRANSPARENT: r_transp <= i_cfg_data[0];
                gcsb_pkg::CFG_SMOOTH:      r_smooth <= i_cfg_data[0];
                gcsb_pkg::CFG_CELL_WIDTH:  r_cell_w <= i_cfg_data[5:0];
                gcsb_pkg::CFG_CELL_HEIGHT: r_cell_h <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic w_adv;
    assign w_adv           = ~o_m_axis_tvalid | i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // input register
    gcsb_pkg::t_tag r_tag_a;
    gcsb_pkg::t_tag n_tag_a;
    logic [6:0]     r_row_a;
    logic [5:0]     r_col_a;

    always_comb begin
        n_tag_a.valid = i_s_axis_tvalid;
        n_tag_a.paint = (i_s_axis_tuser == gcsb_pkg::CMD_PAINT);
        n_tag_a.idx   = i_s_axis_tdata[8:0];
        n_tag_a.wr_ok = (32'(i_s_axis_tdata[8:0]) < GLYPH_WIDTH * GLYPH_HEIGHT);
        n_tag_a.val   = i_s_axis_tdata[16:9];
        n_tag_a.dest  = i_s_axis_tdata[53:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a.valid <= 1'b0;
        end else if (w_adv) begin
            r_tag_a <= n_tag_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_row_a <= i_s_axis_tdata[23:17];
            r_col_a <= i_s_axis_tdata[29:24];
        end
    end

    // scaled position numerators and clamped cell size
    logic [NW-1:0] w_num_x, w_num_y;
    logic [DW-1:0] w_den_x, w_den_y;

    always_comb begin
        if (r_smooth) begin
            w_num_x = NW'((2 * 32'(r_col_a) + 1) * GLYPH_WIDTH * 128);
            w_num_y = NW'((2 * 32'(r_row_a) + 1) * GLYPH_HEIGHT * 128);
        end else begin
            w_num_x = NW'(32'(r_col_a) * GLYPH_WIDTH);
            w_num_y = NW'(32'(r_row_a) * GLYPH_HEIGHT);
        end
        w_den_x = (32'(r_cell_w) < GLYPH_WIDTH) ? DW'(GLYPH_WIDTH) : DW'(r_cell_w);
        w_den_y = (32'(r_cell_h) < GLYPH_HEIGHT) ? DW'(GLYPH_HEIGHT) : DW'(r_cell_h);
    end

    logic [QW-1:0] w_qx, w_qy;

    gcsb_div u_div_x (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_num (w_num_x),
        .i_den (w_den_x),
        .o_quo (w_qx)
    );

    gcsb_div u_div_y (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_num (w_num_y),
        .i_den (w_den_y),
        .o_quo (w_qy)
    );

    // tag line beside the divider stages
    gcsb_pkg::t_tag r_tag_d [1:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= QW; s++) begin
                r_tag_d[s].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_tag_d[1] <= r_tag_a;
            for (int s = 2; s <= QW; s++) begin
                r_tag_d[s] <= r_tag_d[s-1];
            end
        end
    end

    logic [7:0]     w_cov;
    gcsb_pkg::t_tag w_tag_h;

    gcsb_interp #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_smooth (r_smooth),
        .i_qx     (w_qx),
        .i_qy     (w_qy),
        .i_tag    (r_tag_d[QW]),
        .o_cov    (w_cov),
        .o_tag    (w_tag_h)
    );

    logic [23:0] w_pixel;
    logic [7:0]  w_out_cov;
    logic        w_we;

    gcsb_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_fg     (r_fg),
        .i_bg     (r_bg),
        .i_transp (r_transp),
        .i_cov    (w_cov),
        .i_tag    (w_tag_h),
        .o_valid  (o_m_axis_tvalid),
        .o_pixel  (w_pixel),
        .o_cov    (w_out_cov),
        .o_we     (w_we)
    );

    assign o_m_axis_tdata = {w_out_cov, w_pixel};
    assign o_m_axis_tuser = w_we;

    // a suppressed write only comes from transparent mode with zero coverage
    a_no_write_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> r_transp && (w_out_cov == 8'd0))
        else $error("write suppressed without transparent zero coverage");

    // opaque mode always writes
    a_opaque_writes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !r_transp |-> o_m_axis_tuser)
        else $error("opaque mode result without write flag");

    // a frozen pipeline keeps the item leaving the sampler
    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_tag_h) && $stable(w_cov))
        else $error("sampler stage changed during a stall");

    // nearest mode coverage equals one stored entry; in any mode a transparent
    // zero result with write set cannot appear
    a_transp_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_transp && (w_out_cov == 8'd0) |-> !o_m_axis_tuser)
        else $error("transparent zero coverage produced a write");

endmodule
